FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module cpid_chk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside of reset.
`define CPID_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check a property at every rising edge, reset included.
`define CPID_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

FILE: rtl/cpid_pkg.sv
// ----------------------------------------------------------------------------
// cpid_pkg
// Types and constants of the clamped PID controller.
// ----------------------------------------------------------------------------
package cpid_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 20;
    localparam int LIMIT_W    = 15;
    localparam int DRIVE_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // error, error difference and the gain products
    localparam int ERR_W   = SAMPLE_W + 1;
    localparam int DERR_W  = SAMPLE_W + 2;
    localparam int PROD_W  = GAIN_W + 1 + ERR_W;
    localparam int DPROD_W = GAIN_W + 1 + DERR_W;
    localparam int PD_W    = DPROD_W + 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT   = 3'd4;

    localparam logic [LIMIT_W-1:0] INTEG_LIMIT_RST = 15'd300;
    localparam logic [LIMIT_W-1:0] OUT_LIMIT_RST   = 15'd800;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] setpoint;
        logic signed [SAMPLE_W-1:0] measured;
        logic                       clear_integ;
    } t_in;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      out_clamped;
    } t_out;

    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [GAIN_W-1:0]  deriv_gain;
        logic [LIMIT_W-1:0] integ_limit;
        logic [LIMIT_W-1:0] out_limit;
    } t_cfg;

    typedef struct packed {
        logic signed [PROD_W-1:0]  p_term;
        logic signed [PROD_W-1:0]  i_step;
        logic signed [DPROD_W-1:0] d_term;
        logic                      clear_integ;
    } t_prod;

endpackage

FILE: rtl/cpid_cfg.sv
// ----------------------------------------------------------------------------
// cpid_cfg
// Gain and limit registers behind the plain write port.
// ----------------------------------------------------------------------------
module cpid_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cpid_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cpid_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output cpid_pkg::t_cfg                      o_cfg
);

    cpid_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain   <= '0;
            r_cfg.integ_gain  <= '0;
            r_cfg.deriv_gain  <= '0;
            r_cfg.integ_limit <= cpid_pkg::INTEG_LIMIT_RST;
            r_cfg.out_limit   <= cpid_pkg::OUT_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cpid_pkg::CFG_PROP_GAIN: begin
                    r_cfg.prop_gain <= i_cfg_data[cpid_pkg::GAIN_W-1:0];
                end
                cpid_pkg::CFG_INTEG_GAIN: begin
                    r_cfg.integ_gain <= i_cfg_data[cpid_pkg::GAIN_W-1:0];
                end
                cpid_pkg::CFG_DERIV_GAIN: begin
                    r_cfg.deriv_gain <= i_cfg_data[cpid_pkg::GAIN_W-1:0];
                end
                cpid_pkg::CFG_INTEG_LIMIT: begin
                    r_cfg.integ_limit <= i_cfg_data[cpid_pkg::LIMIT_W-1:0];
                end
                cpid_pkg::CFG_OUT_LIMIT: begin
                    r_cfg.out_limit <= i_cfg_data[cpid_pkg::LIMIT_W-1:0];
                end
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/cpid_front.sv
// ----------------------------------------------------------------------------
// cpid_front
// Input register, error forming and the three gain products.
// ----------------------------------------------------------------------------
module cpid_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cpid_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    output logic              o_stall,
    input  cpid_pkg::t_in     i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output cpid_pkg::t_prod   o_prod
);

    logic                                   r_in_valid;
    cpid_pkg::t_in                          r_in;
    logic                                   r_prod_valid;
    cpid_pkg::t_prod                        r_prod;
    logic signed [cpid_pkg::ERR_W-1:0]      r_prev_err;

    logic                                   w_prod_stall;
    logic                                   w_in_stall;
    logic signed [cpid_pkg::ERR_W-1:0]      w_err;
    logic signed [cpid_pkg::DERR_W-1:0]     w_derr;
    logic signed [cpid_pkg::GAIN_W:0]       w_kp;
    logic signed [cpid_pkg::GAIN_W:0]       w_ki;
    logic signed [cpid_pkg::GAIN_W:0]       w_kd;
    cpid_pkg::t_prod                        n_prod;

    assign w_prod_stall = r_prod_valid && i_stall;
    assign w_in_stall   = r_in_valid && w_prod_stall;

    assign w_err  = $signed({r_in.setpoint[cpid_pkg::SAMPLE_W-1], r_in.setpoint})
                  - $signed({r_in.measured[cpid_pkg::SAMPLE_W-1], r_in.measured});
    assign w_derr = $signed({w_err[cpid_pkg::ERR_W-1], w_err})
                  - $signed({r_prev_err[cpid_pkg::ERR_W-1], r_prev_err});

    // gains are unsigned: widen with a zero sign bit
    assign w_kp = $signed({1'b0, i_cfg.prop_gain});
    assign w_ki = $signed({1'b0, i_cfg.integ_gain});
    assign w_kd = $signed({1'b0, i_cfg.deriv_gain});

    always_comb begin
        n_prod.p_term      = w_kp * w_err;
        n_prod.i_step      = w_ki * w_err;
        n_prod.d_term      = w_kd * w_derr;
        n_prod.clear_integ = r_in.clear_integ;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_prod_valid <= 1'b0;
            r_prev_err   <= '0;
        end else begin
            if (!w_in_stall) begin
                r_in_valid <= i_valid;
            end
            if (!w_prod_stall) begin
                r_prod_valid <= r_in_valid;
            end
            // the error of each step becomes the previous error of the next
            if (r_in_valid && !w_prod_stall) begin
                r_prev_err <= w_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !w_in_stall) begin
            r_in <= i_data;
        end
        if (r_in_valid && !w_prod_stall) begin
            r_prod <= n_prod;
        end
    end

    assign o_stall = w_in_stall;
    assign o_valid = r_prod_valid;
    assign o_prod  = r_prod;

endmodule

FILE: rtl/cpid_integ.sv
// ----------------------------------------------------------------------------
// cpid_integ
// Integral accumulate with clamp, and the proportional plus derivative sum.
// ----------------------------------------------------------------------------
module cpid_integ #(
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                                                   i_clk,
    input  logic                                                   i_rst_n,
    input  cpid_pkg::t_cfg                                         i_cfg,
    input  logic                                                   i_valid,
    output logic                                                   o_stall,
    input  cpid_pkg::t_prod                                        i_prod,
    output logic                                                   o_valid,
    input  logic                                                   i_stall,
    output logic signed [cpid_pkg::PD_W-1:0]                       o_pd,
    output logic signed [cpid_pkg::LIMIT_W+GAIN_FRAC_BITS:0]       o_integ
);

    localparam int IW  = cpid_pkg::LIMIT_W + GAIN_FRAC_BITS + 1;
    localparam int ISW = ((IW > cpid_pkg::PROD_W) ? IW : cpid_pkg::PROD_W) + 1;

    logic                                   r_valid;
    logic signed [IW-1:0]                   r_integ;
    logic signed [cpid_pkg::PD_W-1:0]       r_pd;

    logic                                   w_stall;
    logic                                   w_load;
    logic signed [IW-1:0]                   w_base;
    logic signed [ISW-1:0]                  w_isum;
    logic signed [ISW-1:0]                  w_ilim;
    logic signed [ISW-1:0]                  w_nlim;
    logic signed [IW-1:0]                   n_integ;
    logic signed [cpid_pkg::PD_W-1:0]       n_pd;

    assign w_stall = r_valid && i_stall;
    assign w_load  = i_valid && !w_stall;

    assign w_base = i_prod.clear_integ ? '0 : r_integ;
    assign w_isum = ISW'(w_base) + ISW'(i_prod.i_step);
    assign w_ilim = $signed(ISW'({i_cfg.integ_limit, {GAIN_FRAC_BITS{1'b0}}}));
    assign w_nlim = -w_ilim;

    always_comb begin
        if (w_isum > w_ilim) begin
            n_integ = IW'(w_ilim);
        end else if (w_isum < w_nlim) begin
            n_integ = IW'(w_nlim);
        end else begin
            n_integ = IW'(w_isum);
        end
    end

    assign n_pd = cpid_pkg::PD_W'(i_prod.p_term) + cpid_pkg::PD_W'(i_prod.d_term);

    // r_integ is both the loop state and the value handed to the output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_integ <= '0;
        end else begin
            if (!w_stall) begin
                r_valid <= i_valid;
            end
            if (w_load) begin
                r_integ <= n_integ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_pd <= n_pd;
        end
    end

    assign o_stall = w_stall;
    assign o_valid = r_valid;
    assign o_pd    = r_pd;
    assign o_integ = r_integ;

endmodule

FILE: rtl/cpid_out.sv
// ----------------------------------------------------------------------------
// cpid_out
// Output sum, output clamp, truncation toward zero and the result register.
// ----------------------------------------------------------------------------
module cpid_out #(
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                                                   i_clk,
    input  logic                                                   i_rst_n,
    input  cpid_pkg::t_cfg                                         i_cfg,
    input  logic                                                   i_valid,
    output logic                                                   o_stall,
    input  logic signed [cpid_pkg::PD_W-1:0]                       i_pd,
    input  logic signed [cpid_pkg::LIMIT_W+GAIN_FRAC_BITS:0]       i_integ,
    output logic                                                   o_valid,
    input  logic                                                   i_stall,
    output cpid_pkg::t_out                                         o_data
);

    localparam int IW = cpid_pkg::LIMIT_W + GAIN_FRAC_BITS + 1;
    localparam int TW = ((cpid_pkg::PD_W > IW) ? cpid_pkg::PD_W : IW) + 1;

    logic                           r_valid;
    cpid_pkg::t_out                 r_data;

    logic                           w_stall;
    logic signed [TW-1:0]           w_sum;
    logic signed [TW-1:0]           w_olim;
    logic signed [TW-1:0]           w_nlim;
    logic signed [TW-1:0]           w_clip;
    logic                           w_clamped;
    logic signed [TW-1:0]           w_floor;
    logic                           w_round_up;
    logic [TW-1:0]                  w_whole;
    cpid_pkg::t_out                 n_data;

    assign w_stall = r_valid && i_stall;

    assign w_sum  = TW'(i_pd) + TW'(i_integ);
    assign w_olim = $signed(TW'({i_cfg.out_limit, {GAIN_FRAC_BITS{1'b0}}}));
    assign w_nlim = -w_olim;

    always_comb begin
        if (w_sum > w_olim) begin
            w_clip    = w_olim;
            w_clamped = 1'b1;
        end else if (w_sum < w_nlim) begin
            w_clip    = w_nlim;
            w_clamped = 1'b1;
        end else begin
            w_clip    = w_sum;
            w_clamped = 1'b0;
        end
    end

    // floor, then step back toward zero when a negative value has a fraction
    assign w_floor    = w_clip >>> GAIN_FRAC_BITS;
    assign w_round_up = w_clip[TW-1] && (w_clip[GAIN_FRAC_BITS-1:0] != '0);
    assign w_whole    = w_floor + TW'(w_round_up);

    always_comb begin
        n_data.drive       = w_whole[cpid_pkg::DRIVE_W-1:0];
        n_data.out_clamped = w_clamped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!w_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !w_stall) begin
            r_data <= n_data;
        end
    end

    assign o_stall = w_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/clamped_pid_controller.sv
// Path: an input beat moves through the input, product and integral registers
//   into the result register, from which its result beat is offered.
// Throughput: one input beat per cycle unless the result is stalled; the integral
//   loop closes in one add and clamp in its stage; back-to-back steps need no wait.
// Reset: synchronous, active low; clears all valid flags, the integral and the
//   previous error, and loads the default gains (0) and limits (300, 800).
// ----------------------------------------------------------------------------
// clamped_pid_controller
// Positional PID step with a clamped integral and a clamped output.
// ----------------------------------------------------------------------------
module clamped_pid_controller #(
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [cpid_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cpid_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  cpid_pkg::t_in                       i_data,
    // result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output cpid_pkg::t_out                      o_data
);

    // Pipeline:
    //   front : input register -> error, error difference, three products
    //   integ : integral add and clamp (loop state), p + d sum
    //   out   : total, output clamp, truncate toward zero, result register
    // Each stage holds its beat while the next one stalls and takes a new beat
    // whenever it is empty or its content moves on in the same cycle.

    localparam int IW = cpid_pkg::LIMIT_W + GAIN_FRAC_BITS + 1;

    cpid_pkg::t_cfg                         w_cfg;
    logic                                   w_prod_valid;
    logic                                   w_prod_stall;
    cpid_pkg::t_prod                        w_prod;
    logic                                   w_sum_valid;
    logic                                   w_sum_stall;
    logic signed [cpid_pkg::PD_W-1:0]       w_pd;
    logic signed [IW-1:0]                   w_integ;

    cpid_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    cpid_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (w_prod_valid),
        .i_stall (w_prod_stall),
        .o_prod  (w_prod)
    );

    cpid_integ #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_integ (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_prod_valid),
        .o_stall (w_prod_stall),
        .i_prod  (w_prod),
        .o_valid (w_sum_valid),
        .i_stall (w_sum_stall),
        .o_pd    (w_pd),
        .o_integ (w_integ)
    );

    cpid_out #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_sum_valid),
        .o_stall (w_sum_stall),
        .i_pd    (w_pd),
        .i_integ (w_integ),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

FILE: rtl/cpid_chk.sv
// ----------------------------------------------------------------------------
// cpid_chk
// Port-level checks of the clamped PID controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpid_chk (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cpid_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cpid_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_valid,
    input  logic                                o_stall,
    input  cpid_pkg::t_in                       i_data,
    input  logic                                o_valid,
    input  logic                                i_stall,
    input  cpid_pkg::t_out                      o_data
);

    // a held result beat stays offered
    `CPID_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid, "result beat dropped while stalled")

    // a held result beat keeps its payload
    `CPID_ASSERT(a_out_stable, i_clk, i_rst_n, $past(o_valid && i_stall) |-> $stable(o_data), "result payload changed while stalled")

    // back-pressure reaches the input only through a full, stalled output
    `CPID_ASSERT(a_stall_cause, i_clk, i_rst_n, o_stall |-> o_valid && i_stall, "input stalled without a stalled result")

    // the clamp keeps the drive within +-32767
    `CPID_ASSERT(a_drive_range, i_clk, i_rst_n, o_valid |-> o_data.drive != 16'sh8000, "drive outside the clamp range")

    // reset empties the pipeline
    `CPID_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_valid, "result beat offered after reset")

endmodule

bind clamped_pid_controller cpid_chk u_chk (.*);

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the clamped PID controller: a cycle-free model of
// the PID step predicts every result beat, and a checker compares each beat
// field by field as it leaves the block, with random input gaps and stalls.
// ----------------------------------------------------------------------------
module tb;

    localparam int FRAC_BITS      = 16;
    // latency of the block from input beat to result beat, used to size the drain waits
    localparam int RESULT_LATENCY = 3;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_STEPS    = 238;

    // receiver behavior on the result channel
    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_RUNS
    } t_stall_mode;

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            i_cfg_we   = 1'b0;
    logic [cpid_pkg::CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [cpid_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            i_valid    = 1'b0;
    logic                            o_stall;
    cpid_pkg::t_in                   i_data     = '0;
    logic                            o_valid;
    logic                            i_stall    = 1'b0;
    cpid_pkg::t_out                  o_data;

    // mirror of the register file and of the controller state
    cpid_pkg::t_cfg cfg_mirror;
    longint         integ_acc;
    longint         prev_err;

    // expected result beats, oldest first
    cpid_pkg::t_out drive_expect_q[$];

    // sender and receiver pacing
    bit          send_gaps  = 1'b0;
    int          burst_left = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_run  = 0;
    bit          stall_level = 1'b0;

    int fail_count    = 0;
    int steps_sent    = 0;
    int results_seen  = 0;
    int clamped_seen  = 0;
    int config_phases = 0;

    clamped_pid_controller #(
        .GAIN_FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Advance the controller state by one step and return the result beat.
    // All sums are held exactly in 64 bits before the clamps.
    function automatic cpid_pkg::t_out compute_drive(input cpid_pkg::t_in beat);
        longint         err;
        longint         ilim;
        longint         olim;
        longint         sum;
        longint         mag;
        cpid_pkg::t_out res;
        err  = longint'($signed(beat.setpoint)) - longint'($signed(beat.measured));
        ilim = longint'(cfg_mirror.integ_limit) <<< FRAC_BITS;
        olim = longint'(cfg_mirror.out_limit) <<< FRAC_BITS;

        // clear first, then integrate and clamp the integral
        if (beat.clear_integ)
            integ_acc = 0;
        integ_acc += longint'(cfg_mirror.integ_gain) * err;
        if (integ_acc > ilim)
            integ_acc = ilim;
        if (integ_acc < -ilim)
            integ_acc = -ilim;

        sum = longint'(cfg_mirror.prop_gain) * err + integ_acc
            + longint'(cfg_mirror.deriv_gain) * (err - prev_err);

        // a sum exactly on the limit passes unclamped
        res.out_clamped = 1'b0;
        if (sum > olim) begin
            sum = olim;
            res.out_clamped = 1'b1;
        end
        if (sum < -olim) begin
            sum = -olim;
            res.out_clamped = 1'b1;
        end

        // drop the fraction toward zero, not toward minus infinity
        mag = (sum < 0) ? -sum : sum;
        mag = mag >>> FRAC_BITS;
        res.drive = cpid_pkg::DRIVE_W'((sum < 0) ? -mag : mag);

        prev_err = err;
        return res;
    endfunction

    function automatic cpid_pkg::t_in make_step(input int sp, input int ms, input bit clr);
        cpid_pkg::t_in beat;
        beat.setpoint    = cpid_pkg::SAMPLE_W'(sp);
        beat.measured    = cpid_pkg::SAMPLE_W'(ms);
        beat.clear_integ = clr;
        return beat;
    endfunction

    // ------------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------------

    // Drive one register write and mirror it. The write enable stays high so
    // that back-to-back writes follow without a gap; callers lower it.
    task automatic write_reg(input logic [cpid_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cpid_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            cpid_pkg::CFG_PROP_GAIN:
                cfg_mirror.prop_gain   = data[cpid_pkg::GAIN_W-1:0];
            cpid_pkg::CFG_INTEG_GAIN:
                cfg_mirror.integ_gain  = data[cpid_pkg::GAIN_W-1:0];
            cpid_pkg::CFG_DERIV_GAIN:
                cfg_mirror.deriv_gain  = data[cpid_pkg::GAIN_W-1:0];
            cpid_pkg::CFG_INTEG_LIMIT:
                cfg_mirror.integ_limit = data[cpid_pkg::LIMIT_W-1:0];
            cpid_pkg::CFG_OUT_LIMIT:
                cfg_mirror.out_limit   = data[cpid_pkg::LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [cpid_pkg::CFG_DATA_W-1:0] pg,
                               input logic [cpid_pkg::CFG_DATA_W-1:0] ig,
                               input logic [cpid_pkg::CFG_DATA_W-1:0] dg,
                               input logic [cpid_pkg::CFG_DATA_W-1:0] il,
                               input logic [cpid_pkg::CFG_DATA_W-1:0] ol);
        write_reg(cpid_pkg::CFG_PROP_GAIN, pg);
        write_reg(cpid_pkg::CFG_INTEG_GAIN, ig);
        write_reg(cpid_pkg::CFG_DERIV_GAIN, dg);
        write_reg(cpid_pkg::CFG_INTEG_LIMIT, il);
        write_reg(cpid_pkg::CFG_OUT_LIMIT, ol);
        i_cfg_we <= 1'b0;
        config_phases++;
    endtask

    // Hold the input side idle until every expected beat has come out, then
    // let the pipeline run empty before the registers may change.
    task automatic settle();
        i_valid    <= 1'b0;
        burst_left = 0;
        while (drive_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (RESULT_LATENCY + 2) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Input channel
    // ------------------------------------------------------------------------

    // Send one input beat. Between bursts, with gaps enabled, the sender may drop
    // valid for a random gap; inside a burst valid stays high from beat to beat.
    task automatic send_step(input cpid_pkg::t_in beat);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (send_gaps) begin
                gap = $urandom_range(0, 6);
                if (gap != 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_data  <= beat;
        // hold the beat until the block takes it
        do @(posedge i_clk); while (o_stall);
        drive_expect_q.push_back(compute_drive(beat));
        steps_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Result channel: check each beat, then pick the next stall value
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        cpid_pkg::t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (o_data.out_clamped)
                clamped_seen++;
            if (drive_expect_q.size() == 0) begin
                $error("result beat with no step waiting: drive %0d, out_clamped %0b",
                       o_data.drive, o_data.out_clamped);
                fail_count++;
            end else begin
                want = drive_expect_q.pop_front();
                if (o_data.drive !== want.drive) begin
                    $error("drive: expected %0d, got %0d", want.drive, o_data.drive);
                    fail_count++;
                end
                if (o_data.out_clamped !== want.out_clamped) begin
                    $error("out_clamped: expected %0b, got %0b",
                           want.out_clamped, o_data.out_clamped);
                    fail_count++;
                end
            end
        end

        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            case (stall_mode)
                STALL_RANDOM: i_stall <= ($urandom_range(0, 99) < 35);
                STALL_RUNS: begin
                    // alternate runs of stall and flow of random length
                    if (stall_run == 0) begin
                        stall_run   = $urandom_range(1, 12);
                        stall_level = ~stall_level;
                    end
                    stall_run--;
                    i_stall <= stall_level;
                end
                default: i_stall <= 1'b0;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset defaults: zero gains give a zero drive whatever the error.
    task automatic test_reset_defaults();
        send_step(make_step(1000, -1000, 1'b0));
        send_step(make_step(-32768, 32767, 1'b1));
        settle();
    endtask

    // Clamp boundary: a sum exactly on a limit is not clamped, one past it is.
    task automatic test_clamp_boundary();
        load_config(20'h10000, 20'h0, 20'h0, 20'd300, 20'd800);
        send_step(make_step(800, 0, 1'b0));
        send_step(make_step(0, 800, 1'b0));
        send_step(make_step(801, 0, 1'b0));
        send_step(make_step(0, 801, 1'b0));
        settle();
        // integral alone: reach the integral limit exactly, then push past it
        load_config(20'h0, 20'h10000, 20'h0, 20'd300, 20'd800);
        send_step(make_step(300, 0, 1'b1));
        send_step(make_step(1, 0, 1'b0));
        send_step(make_step(-600, 0, 1'b0));
        settle();
    endtask

    // Negative fractions: truncate toward zero (gain 1.5).
    task automatic test_truncation();
        load_config(20'h18000, 20'h0, 20'h0, 20'd300, 20'd800);
        send_step(make_step(-3, 0, 1'b0));
        send_step(make_step(3, 0, 1'b0));
        send_step(make_step(0, 1, 1'b0));
        settle();
    endtask

    // Zero limits force integral and drive to zero; then the widest limits
    // with the largest gains and the largest errors of both signs.
    task automatic test_limit_extremes();
        load_config(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'd0, 20'd0);
        send_step(make_step(32767, -32768, 1'b1));
        send_step(make_step(-32768, 32767, 1'b0));
        send_step(make_step(0, 0, 1'b0));
        settle();
        load_config(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'd32767, 20'd32767);
        send_step(make_step(32767, -32768, 1'b0));
        send_step(make_step(-32768, 32767, 1'b1));
        settle();
    endtask

    // Upper data bits of the limit registers and writes to unused indexes
    // must leave the register file alone.
    task automatic test_register_masking();
        write_reg(cpid_pkg::CFG_PROP_GAIN, 20'h10000);
        write_reg(cpid_pkg::CFG_INTEG_GAIN, 20'h0);
        write_reg(cpid_pkg::CFG_DERIV_GAIN, 20'h0);
        write_reg(cpid_pkg::CFG_INTEG_LIMIT, {5'h1F, 15'd40});
        write_reg(cpid_pkg::CFG_OUT_LIMIT, {5'h1F, 15'd100});
        for (int idx = cpid_pkg::CFG_OUT_LIMIT + 1; idx < (1 << cpid_pkg::CFG_IDX_W); idx++)
            write_reg(cpid_pkg::CFG_IDX_W'(idx), '1);
        i_cfg_we <= 1'b0;
        config_phases++;
        send_step(make_step(500, 0, 1'b1));
        send_step(make_step(-50, 0, 1'b0));
        settle();
    endtask

    function automatic logic [cpid_pkg::CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return cpid_pkg::CFG_DATA_W'($urandom_range(0, 20'h20000));
            4:       return cpid_pkg::CFG_DATA_W'($urandom);
            default: return cpid_pkg::CFG_DATA_W'($urandom_range(0, 20'h1000));
        endcase
    endfunction

    // Limits carry random upper data bits, which the block must drop.
    function automatic logic [cpid_pkg::CFG_DATA_W-1:0] pick_limit();
        logic [cpid_pkg::LIMIT_W-1:0] lim;
        case ($urandom_range(0, 5))
            0:       lim = '0;
            1:       lim = '1;
            2:       lim = cpid_pkg::LIMIT_W'($urandom_range(1, 50));
            3:       lim = cpid_pkg::LIMIT_W'($urandom_range(100, 2000));
            default: lim = cpid_pkg::LIMIT_W'($urandom);
        endcase
        return {5'($urandom), lim};
    endfunction

    // Random phases. Most steps follow a tracking loop: the setpoint holds
    // for a while and the measurement sits near it, so the integral winds up
    // against its clamp. The rest are full-range noise and field extremes.
    task automatic test_random_steps();
        int            sp_hold;
        int            sp_track;
        int            ms;
        int            spread;
        cpid_pkg::t_in beat;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            load_config(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit());
            // the first phase runs with no idling at all
            send_gaps  = (phase != 0) && ($urandom_range(0, 3) != 0);
            stall_mode = (phase == 0) ? STALL_NONE : t_stall_mode'($urandom_range(0, 2));
            sp_hold  = 0;
            sp_track = 0;
            spread   = 1 << $urandom_range(2, 12);
            for (int n = 0; n < PHASE_STEPS; n++) begin
                if (sp_hold == 0) begin
                    sp_hold  = $urandom_range(5, 40);
                    sp_track = $signed(16'($urandom));
                end
                sp_hold--;
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4: begin
                        beat = make_step($urandom, $urandom, $urandom_range(0, 15) == 0);
                    end
                    5, 6, 7: begin
                        beat = make_step($urandom_range(0, 1) ? 32767 : -32768,
                                         $urandom_range(0, 2) == 0 ? 0 :
                                         ($urandom_range(0, 1) ? 32767 : -32768),
                                         $urandom_range(0, 7) == 0);
                    end
                    default: begin
                        ms = sp_track + $urandom_range(0, 2 * spread) - spread;
                        if (ms > 32767)
                            ms = 32767;
                        if (ms < -32768)
                            ms = -32768;
                        beat = make_step(sp_track, ms, $urandom_range(0, 31) == 0);
                    end
                endcase
                send_step(beat);
            end
            settle();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        cfg_mirror.prop_gain   = '0;
        cfg_mirror.integ_gain  = '0;
        cfg_mirror.deriv_gain  = '0;
        cfg_mirror.integ_limit = cpid_pkg::INTEG_LIMIT_RST;
        cfg_mirror.out_limit   = cpid_pkg::OUT_LIMIT_RST;
        integ_acc = 0;
        prev_err  = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_clamp_boundary();
        test_truncation();
        test_limit_extremes();
        test_register_masking();
        test_random_steps();

        settle();
        repeat (4 * RESULT_LATENCY) @(posedge i_clk);

        $display("%0d steps sent over %0d register settings; %0d result beats checked,",
                 steps_sent, config_phases, results_seen);
        $display("%0d of them with the output clamped", clamped_seen);
        if (fail_count == 0 && drive_expect_q.size() == 0) begin
            $display("** clamped_pid_controller: PASSED **");
        end else begin
            $display("** clamped_pid_controller: FAILED **");
        end
        $finish;
    end

    // Bound the run: far beyond the slowest correct run with every stall.
    initial begin
        #10_000_000;
        $display("timeout with %0d result beats still expected", drive_expect_q.size());
        $display("** clamped_pid_controller: FAILED **");
        $finish;
    end

endmodule
